@@ rtl/ncs_pkg.sv @@
package ncs_pkg;

    localparam int DEF_MAX_CENTROIDS = 256;
    localparam int DEF_MAX_DIMS      = 32;

    localparam int VALUE_W = 16;
    localparam int SLOT_W  = 8;
    localparam int COMP_W  = 5;
    localparam int INDEX_W = 8;
    localparam int DIFF_W  = VALUE_W + 1;
    localparam int SQ_W    = 2 * VALUE_W + 1;

    localparam int DIMS_W = 6;
    localparam int CENT_W = 9;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int REG_ADDR_BIT = 2;

    localparam logic [DIMS_W-1:0] RESET_DIMS      = 6'd4;
    localparam logic [CENT_W-1:0] RESET_CENTROIDS = 9'd256;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam int DRAIN_CYCLES = 4;

    typedef enum logic {
        REG_DIMS      = 1'b0,
        REG_CENTROIDS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic first_k;
        logic last_k;
        logic load_result;
    } ctrl_cmd_t;

endpackage

@@ rtl/ncs_if.sv @@
interface ncs_in_if;
    import ncs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [SLOT_W-1:0]         centroid_slot;
    logic [COMP_W-1:0]         component_index;
    logic signed [VALUE_W-1:0] component_value;
    logic                      query_last;

    modport source (
        output valid, mode, centroid_slot, component_index, component_value, query_last,
        input  ready
    );
    modport sink (
        input  valid, mode, centroid_slot, component_index, component_value, query_last,
        output ready
    );
endinterface

interface ncs_out_if;
    import ncs_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] nearest_index;

    modport source (
        output valid, nearest_index,
        input  ready
    );
    modport sink (
        input  valid, nearest_index,
        output ready
    );
endinterface

@@ rtl/ncs_ram.sv @@
module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/ncs_regs.sv @@
module ncs_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ncs_pkg::PADDR_W-1:0]  paddr,
    input  logic [ncs_pkg::DATA_W-1:0]   pwdata,
    output logic [ncs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [ncs_pkg::DIMS_W-1:0]   dims_cfg,
    output logic [ncs_pkg::CENT_W-1:0]   cents_cfg
);
    import ncs_pkg::*;

    logic [DIMS_W-1:0] dims_reg;
    logic [CENT_W-1:0] cents_reg;
    logic              wr_en;
    reg_index_t        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_index_t'(paddr[REG_ADDR_BIT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg  <= RESET_DIMS;
            cents_reg <= RESET_CENTROIDS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DIMS:      dims_reg  <= pwdata[DIMS_W-1:0];
                REG_CENTROIDS: cents_reg <= pwdata[CENT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DIMS:      prdata = DATA_W'(dims_reg);
            REG_CENTROIDS: prdata = DATA_W'(cents_reg);
        endcase
    end

    assign dims_cfg  = dims_reg;
    assign cents_cfg = cents_reg;

endmodule

@@ rtl/ncs_ctrl.sv @@
module ncs_ctrl #(
    parameter int MAX_CENTROIDS = ncs_pkg::DEF_MAX_CENTROIDS,
    parameter int MAX_DIMS      = ncs_pkg::DEF_MAX_DIMS,
    parameter int CIW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
    parameter int KIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ncs_pkg::DIMS_W-1:0] dims_cfg,
    input  logic [ncs_pkg::CENT_W-1:0] cents_cfg,
    input  logic                       in_accept,
    input  logic                       in_search,
    input  logic                       out_ready,
    output logic                       in_ready,
    output logic                       out_valid,
    output ncs_pkg::ctrl_cmd_t         cmd,
    output logic [CIW-1:0]             c_idx,
    output logic [KIW-1:0]             k_idx
);
    import ncs_pkg::*;

    localparam int NW = $clog2(MAX_CENTROIDS + 1);
    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int DRW = $clog2(DRAIN_CYCLES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t         state_reg, state_next;
    logic [CIW-1:0] c_reg, c_next;
    logic [KIW-1:0] k_reg, k_next;
    logic [DRW-1:0] drain_reg, drain_next;
    logic           out_valid_reg, out_valid_next;
    logic [NW-1:0]  n_use;
    logic [DW-1:0]  d_use;
    logic           last_k, last_c;

    // clamp the register values to the storage that exists
    assign n_use = (32'(cents_cfg) > 32'(MAX_CENTROIDS)) ? NW'(MAX_CENTROIDS) : NW'(cents_cfg);
    assign d_use = (32'(dims_cfg) > 32'(MAX_DIMS)) ? DW'(MAX_DIMS) : DW'(dims_cfg);

    assign last_k = (32'(k_reg) + 32'd1 == 32'(d_use));
    assign last_c = (32'(c_reg) + 32'd1 == 32'(n_use));

    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_search)
                begin
                    cmd.start  = 1'b1;
                    c_next     = '0;
                    k_next     = '0;
                    drain_next = '0;
                    // empty search: best stays at index zero
                    if (n_use == '0 || d_use == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue   = 1'b1;
                cmd.first_k = (k_reg == '0);
                cmd.last_k  = last_k;
                if (last_k)
                begin
                    k_next = '0;
                    if (last_c)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (32'(drain_reg) == DRAIN_CYCLES - 1)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            c_reg         <= '0;
            k_reg         <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign c_idx     = c_reg;
    assign k_idx     = k_reg;

    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (32'(k_reg) < 32'(d_use)) && (32'(c_reg) < 32'(n_use)))
        else $error("search counters left the range in use");

    a_search_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_search |=> !in_ready)
        else $error("input still ready after a search item");

endmodule

@@ rtl/ncs_dp.sv @@
module ncs_dp #(
    parameter int MAX_CENTROIDS = ncs_pkg::DEF_MAX_CENTROIDS,
    parameter int MAX_DIMS      = ncs_pkg::DEF_MAX_DIMS,
    parameter int CIW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
    parameter int KIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_accept,
    input  logic                        mode,
    input  logic [ncs_pkg::SLOT_W-1:0]  centroid_slot,
    input  logic [ncs_pkg::COMP_W-1:0]  component_index,
    input  logic [ncs_pkg::VALUE_W-1:0] component_value,
    input  ncs_pkg::ctrl_cmd_t          cmd,
    input  logic [CIW-1:0]              c_idx,
    input  logic [KIW-1:0]              k_idx,
    output logic [ncs_pkg::INDEX_W-1:0] nearest_index
);
    import ncs_pkg::*;

    localparam int STORE_DEPTH = MAX_CENTROIDS * MAX_DIMS;
    localparam int SAW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ACC_W = SQ_W + $clog2(MAX_DIMS);

    logic               slot_ok, comp_ok;
    logic               store_we, query_we;
    logic [SAW-1:0]     store_waddr, store_raddr;
    logic [KIW-1:0]     query_waddr;
    logic [VALUE_W-1:0] c_data, q_data;

    logic                     s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [CIW-1:0]           s1_c_reg;
    logic                     s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [CIW-1:0]           s2_c_reg;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic                     s3_valid_reg, s3_first_reg, s3_last_reg;
    logic [CIW-1:0]           s3_c_reg;
    logic signed [2*DIFF_W-1:0] prod;
    logic [SQ_W-1:0]          sq_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic                     sum_valid_reg;
    logic [ACC_W-1:0]         sum_reg;
    logic [CIW-1:0]           sum_c_reg;
    logic                     have_best_reg;
    logic [ACC_W-1:0]         best_reg;
    logic [CIW-1:0]           best_idx_reg;
    logic [INDEX_W-1:0]       out_index_reg;

    // drop element writes that fall outside the storage
    assign slot_ok  = 32'(centroid_slot) < 32'(MAX_CENTROIDS);
    assign comp_ok  = 32'(component_index) < 32'(MAX_DIMS);
    assign store_we = in_accept && (mode == MODE_LOAD) && slot_ok && comp_ok;
    assign query_we = in_accept && (mode == MODE_QUERY) && comp_ok;

    assign store_waddr = SAW'(32'(centroid_slot) * 32'(MAX_DIMS) + 32'(component_index));
    assign query_waddr = KIW'(component_index);
    assign store_raddr = SAW'(32'(c_idx) * 32'(MAX_DIMS) + 32'(k_idx));

    ncs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH),
        .AW    (SAW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (component_value),
        .re    (cmd.issue),
        .raddr (store_raddr),
        .rdata (c_data)
    );

    ncs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_DIMS),
        .AW    (KIW)
    ) u_query (
        .clk   (clk),
        .we    (query_we),
        .waddr (query_waddr),
        .wdata (component_value),
        .re    (cmd.issue),
        .raddr (k_idx),
        .rdata (q_data)
    );

    assign diff_next = DIFF_W'($signed(c_data)) - DIFF_W'($signed(q_data));
    assign prod      = diff_reg * diff_reg;
    assign acc_next  = (s3_first_reg ? '0 : acc_reg) + ACC_W'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            have_best_reg <= 1'b0;
            best_idx_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            sum_valid_reg <= s3_valid_reg && s3_last_reg;
            if (cmd.start)
            begin
                have_best_reg <= 1'b0;
                best_idx_reg  <= '0;
            end
            else if (sum_valid_reg && (!have_best_reg || sum_reg < best_reg))
            begin
                // strict compare keeps the lower index on a tie
                have_best_reg <= 1'b1;
                best_idx_reg  <= sum_c_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first_k;
        s1_last_reg  <= cmd.last_k;
        s1_c_reg     <= c_idx;

        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_c_reg     <= s1_c_reg;
        diff_reg     <= diff_next;

        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_c_reg     <= s2_c_reg;
        sq_reg       <= prod[SQ_W-1:0];

        if (s3_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s3_valid_reg && s3_last_reg)
        begin
            sum_reg   <= acc_next;
            sum_c_reg <= s3_c_reg;
        end

        if (sum_valid_reg && (!have_best_reg || sum_reg < best_reg))
        begin
            best_reg <= sum_reg;
        end

        if (cmd.load_result)
        begin
            out_index_reg <= INDEX_W'(best_idx_reg);
        end
    end

    assign nearest_index = out_index_reg;

    a_start_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !(s1_valid_reg || s2_valid_reg || s3_valid_reg || sum_valid_reg))
        else $error("search started with the pipeline busy");

    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !(s1_valid_reg || s2_valid_reg || s3_valid_reg || sum_valid_reg))
        else $error("result taken before the pipeline drained");

    a_sum_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg |-> $past(s3_valid_reg) && $past(s3_last_reg))
        else $error("distance closed without a last component");

endmodule

@@ rtl/nearest_centroid_search.sv @@
// Channel   Dir  Payload                                                      Accepted when
// in_ch     in   mode, centroid_slot, component_index, component_value,       valid && ready
//                query_last
// out_ch    out  nearest_index                                                valid && ready
// apb       in   dims_in_use @ 0x0, centroids_in_use @ 0x4                    psel && penable
//                                                                              && pwrite
//
// A load item or a query item without the last mark is taken without stalling the input.
// A search item walks the n*d stored components before its result shows on out_ch,
// where n and d are the clamped centroid and dimension counts: one store read and
// one multiply-accumulate per cycle through a four-stage pipeline, then a drain.
// The input stays stalled while a search runs; a result still waiting on out_ch
// holds only the end of the next search, not the loads and query items before it.
// Reset sets the registers to 4 dimensions and 256 centroids; the centroid store and
// the query buffer are not cleared and hold garbage until written.
module nearest_centroid_search #(
    parameter int MAX_CENTROIDS = ncs_pkg::DEF_MAX_CENTROIDS,
    parameter int MAX_DIMS      = ncs_pkg::DEF_MAX_DIMS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ncs_in_if.sink                      in_ch,
    ncs_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ncs_pkg::PADDR_W-1:0] paddr,
    input  logic [ncs_pkg::DATA_W-1:0]  pwdata,
    output logic [ncs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ncs_pkg::*;

    localparam int CIW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int KIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [DIMS_W-1:0] dims_cfg;
    logic [CENT_W-1:0] cents_cfg;
    logic              in_ready;
    logic              in_accept;
    logic              in_search;
    ctrl_cmd_t         cmd;
    logic [CIW-1:0]    c_idx;
    logic [KIW-1:0]    k_idx;

    assign in_ch.ready = in_ready;
    assign in_accept   = in_ch.valid && in_ready;
    // a query item carrying the last mark starts the search; the mark on a load is ignored
    assign in_search   = (in_ch.mode == MODE_QUERY) && in_ch.query_last;

    ncs_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .dims_cfg  (dims_cfg),
        .cents_cfg (cents_cfg)
    );

    // sequence the centroid and component walk, own the handshakes
    ncs_ctrl #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_DIMS      (MAX_DIMS),
        .CIW           (CIW),
        .KIW           (KIW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims_cfg  (dims_cfg),
        .cents_cfg (cents_cfg),
        .in_accept (in_accept),
        .in_search (in_search),
        .out_ready (out_ch.ready),
        .in_ready  (in_ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd),
        .c_idx     (c_idx),
        .k_idx     (k_idx)
    );

    // hold the vectors, compute distances, track the best index
    ncs_dp #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_DIMS      (MAX_DIMS),
        .CIW           (CIW),
        .KIW           (KIW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_accept       (in_accept),
        .mode            (in_ch.mode),
        .centroid_slot   (in_ch.centroid_slot),
        .component_index (in_ch.component_index),
        .component_value (in_ch.component_value),
        .cmd             (cmd),
        .c_idx           (c_idx),
        .k_idx           (k_idx),
        .nearest_index   (out_ch.nearest_index)
    );

endmodule
